@@ hdl/lsr_pkg.sv @@
// Package for the LIFO stack with reverse: depth, derived widths, command and
// status codes, controller states and the address mapping function.
// No dependencies.
package lsr_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;

    typedef enum logic [2:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_DISPLAY = 3'd3,
        OP_REVERSE = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DISP
    } t_state;

    // Map a logical position (0 = bottom) to a RAM address.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] pos,
                                             input logic          dir);
        logic [AW:0] s;
        if (!dir) begin
            s = {1'b0, base} + {1'b0, pos};
            if (s >= (AW+1)'(DEPTH)) begin
                s = s - (AW+1)'(DEPTH);
            end
        end else begin
            if (base >= pos) begin
                s = {1'b0, base} - {1'b0, pos};
            end else begin
                s = {1'b0, base} + (AW+1)'(DEPTH) - {1'b0, pos};
            end
        end
        return s[AW-1:0];
    endfunction

endpackage

@@ hdl/lsr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lifo_stack_with_reverse_unit.sv @@
// Top level of the LIFO stack with reverse: controller, counters, output register.
// Depends on lsr_pkg and lsr_ram.
//
// A bounded stack of DEPTH signed 32-bit words held in one RAM with a registered
// read. Push, a full or empty status, and reverse are answered from the idle state;
// reverse is constant time because it moves the base address to the old top and
// flips the walking direction instead of moving words. Pop and peek go through
// the read state to wait for the registered RAM read. Display of n words yields one
// word per cycle through the single RAM read port while the output is not stalled.
// One command is in flight at a time; the next is taken only once the previous one
// has placed its last result in the output register and that register is empty or
// being read in the same cycle, so a result held downstream stalls the input. The
// RAM needs no clearing after reset: the entry count guards every read.
module lifo_stack_with_reverse_unit import lsr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [2:0]           i_opcode,
    input  logic signed [DW-1:0] i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_status,
    output logic signed [DW-1:0] o_data,
    output logic                 o_last
);

    t_state           r_state,    n_state;
    logic [CW-1:0]    r_count,    n_count;
    logic [AW-1:0]    r_base,     n_base;
    logic             r_dir,      n_dir;
    logic [AW-1:0]    r_idx,      n_idx;
    logic             r_pop,      n_pop;
    logic             r_o_valid,  n_o_valid;
    t_status          r_o_status, n_o_status;
    logic [DW-1:0]    r_o_data,   n_o_data;
    logic             r_o_last,   n_o_last;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [DW-1:0]    ram_rdata;

    logic             out_free;
    logic             in_acc;
    logic             is_empty;
    logic             is_full;
    logic [AW-1:0]    top_pos;

    lsr_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_value),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign in_acc   = i_valid && !o_stall;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));
    assign top_pos  = AW'(r_count - CW'(1));

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_data   = r_o_data;
    assign o_last   = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_base    <= '0;
            r_dir     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_base    <= n_base;
            r_dir     <= n_dir;
            r_o_valid <= n_o_valid;
        end
        r_idx      <= n_idx;
        r_pop      <= n_pop;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_base     = r_base;
        n_dir      = r_dir;
        n_idx      = r_idx;
        n_pop      = r_pop;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_data   = r_o_data;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = f_phys(r_base, AW'(r_count), r_dir);
        ram_re     = 1'b0;
        ram_raddr  = f_phys(r_base, top_pos, r_dir);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_o_status = ST_OK;
                    n_o_data   = '0;
                    n_o_last   = 1'b1;
                    case (i_opcode)
                        OP_PUSH: begin
                            n_o_valid = 1'b1;
                            if (is_full) begin
                                n_o_status = ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (is_empty) begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_pop   = (i_opcode == OP_POP);
                                n_state = S_READ;
                            end
                        end
                        OP_DISPLAY: begin
                            if (is_empty) begin
                                n_o_valid  = 1'b1;
                                n_o_status = ST_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_idx   = top_pos;
                                n_state = S_DISP;
                            end
                        end
                        OP_REVERSE: begin
                            n_o_valid = 1'b1;
                            if (is_empty) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                n_base = f_phys(r_base, top_pos, r_dir);
                                n_dir  = !r_dir;
                            end
                        end
                        default: begin
                            n_o_valid = r_o_valid && i_stall;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_data   = ram_rdata;
                    n_o_last   = 1'b1;
                    if (r_pop) begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                ram_raddr = f_phys(r_base, r_idx - AW'(1), r_dir);
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_data   = ram_rdata;
                    n_o_last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re = 1'b1;
                        n_idx  = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_PUSH && !is_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the stack");

    a_disp_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP || r_state == S_READ) |-> !is_empty)
        else $error("memory read on an empty stack");

    a_disp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISP && out_free && r_idx != '0) |=> (r_state == S_DISP && !r_o_last))
        else $error("display ended early");

endmodule

@@ dv/tb_lifo_stack_with_reverse_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lifo_stack_with_reverse_unit: directed and random command
// streams with bursty input and stalling output, checked against a local stack predictor.
// Depends on lsr_pkg and the RTL of the block.
module tb_lifo_stack_with_reverse_unit import lsr_pkg::*;;

    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          RANDOM_ITEMS   = 160;
    localparam logic [2:0]  OP_RSVD_FIRST  = 3'd5;
    localparam logic [2:0]  OP_RSVD_LAST   = 3'd7;

    typedef struct {
        logic [1:0]           status;
        logic signed [DW-1:0] data;
        logic                 last;
    } t_stack_reply;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic                 o_stall;
    logic [2:0]           i_opcode = OP_PUSH;
    logic signed [DW-1:0] i_value  = '0;
    logic                 o_valid;
    logic                 i_stall  = 1'b0;
    logic [1:0]           o_status;
    logic signed [DW-1:0] o_data;
    logic                 o_last;

    t_stack_reply         expected_replies[$];
    logic signed [DW-1:0] model_words[DEPTH];
    int                   model_count;

    int mismatch_count  = 0;
    int replies_checked = 0;
    int cycle_count     = 0;
    int op_count[8];
    int full_hits       = 0;
    int empty_hits      = 0;

    int tx_mode       = 0;
    int tx_burst_left = 0;
    int rx_mode       = 0;
    bit rx_hold_req   = 1'b0;

    lifo_stack_with_reverse_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_opcode),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_data   (o_data),
        .o_last   (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies pending", cycle_count,
                 expected_replies.size());
        $display("lifo_stack_with_reverse_unit test failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    function automatic void add_reply(input t_status st, input logic signed [DW-1:0] d,
                                      input logic lst);
        t_stack_reply r;
        r.status = st;
        r.data   = d;
        r.last   = lst;
        expected_replies.push_back(r);
        if (st == ST_FULL) full_hits++;
        if (st == ST_EMPTY) empty_hits++;
    endfunction

    function automatic void predict_replies(input logic [2:0] op,
                                            input logic signed [DW-1:0] val);
        logic signed [DW-1:0] t;
        op_count[op]++;
        case (op)
            OP_PUSH: begin
                if (model_count >= DEPTH) begin
                    add_reply(ST_FULL, '0, 1'b1);
                end else begin
                    model_words[model_count] = val;
                    model_count++;
                    add_reply(ST_OK, '0, 1'b1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (model_count == 0) begin
                    add_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    add_reply(ST_OK, model_words[model_count-1], 1'b1);
                    if (op == OP_POP) model_count--;
                end
            end
            OP_DISPLAY: begin
                if (model_count == 0) begin
                    add_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = model_count - 1; i >= 0; i--) begin
                        add_reply(ST_OK, model_words[i], i == 0);
                    end
                end
            end
            OP_REVERSE: begin
                if (model_count == 0) begin
                    add_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < model_count / 2; i++) begin
                        t = model_words[i];
                        model_words[i] = model_words[model_count-1-i];
                        model_words[model_count-1-i] = t;
                    end
                    add_reply(ST_OK, '0, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic signed [DW-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(DW-1){1'b0}}};
            1:       return {1'b0, {(DW-1){1'b1}}};
            2:       return '1;
            3:       return DW'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // Call right after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_cmd(input logic [2:0] op, input logic signed [DW-1:0] val);
        int gap;
        if (tx_burst_left == 0) begin
            case (tx_mode)
                0:       gap = 0;
                1:       gap = $urandom_range(0, 3);
                default: gap = $urandom_range(1, 10);
            endcase
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            tx_burst_left = (tx_mode == 0) ? 32 : $urandom_range(1, 8);
        end
        tx_burst_left--;
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_replies(op, val);
    endtask

    task automatic wait_all_replies();
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_stack();
        tx_mode = 1;
        rx_mode = 1;
        send_cmd(OP_POP, random_word());
        send_cmd(OP_PEEK, random_word());
        send_cmd(OP_DISPLAY, random_word());
        send_cmd(OP_REVERSE, random_word());
        for (int c = OP_RSVD_FIRST; c <= OP_RSVD_LAST; c++) begin
            send_cmd(3'(c), '1);
        end
        wait_all_replies();
    endtask

    task automatic test_word_extremes();
        send_cmd(OP_PUSH, {1'b1, {(DW-1){1'b0}}});
        send_cmd(OP_PUSH, {1'b0, {(DW-1){1'b1}}});
        send_cmd(OP_PUSH, '1);
        send_cmd(OP_PUSH, '0);
        send_cmd(OP_PEEK, '0);
        send_cmd(OP_DISPLAY, '0);
        send_cmd(OP_REVERSE, '0);
        send_cmd(OP_DISPLAY, '1);
        send_cmd(OP_POP, '0);
        send_cmd(OP_POP, '1);
        send_cmd(OP_REVERSE, '0);
        send_cmd(OP_PEEK, '0);
        wait_all_replies();
    endtask

    task automatic test_fill_to_overflow();
        tx_mode = 0;
        rx_mode = 0;
        while (model_count < DEPTH) send_cmd(OP_PUSH, random_word());
        send_cmd(OP_PUSH, random_word());
        send_cmd(OP_DISPLAY, '0);
        send_cmd(OP_REVERSE, '0);
        send_cmd(OP_DISPLAY, '0);
        send_cmd(OP_POP, '0);
        send_cmd(OP_PUSH, random_word());
        send_cmd(OP_PUSH, random_word());
        wait_all_replies();
    endtask

    task automatic test_backpressure_hold();
        logic [2:0] op;
        tx_mode = 0;
        rx_hold_req = 1'b1;
        for (int n = 0; n < 24; n++) begin
            op = 3'($urandom_range(OP_PUSH, OP_REVERSE));
            send_cmd(op, random_word());
        end
        wait_all_replies();
    endtask

    task automatic test_random_mix(input int n_items);
        int         done;
        int         seg;
        int         bias;
        int         roll;
        logic [2:0] op;
        done = 0;
        seg  = 0;
        bias = 0;
        while (done < n_items) begin
            if (seg == 0) begin
                seg     = $urandom_range(15, 40);
                bias    = $urandom_range(0, 2);
                tx_mode = $urandom_range(0, 2);
                rx_mode = $urandom_range(0, 2);
            end
            roll = $urandom_range(0, 99);
            case (bias)
                0:       op = (roll < 70) ? OP_PUSH : (roll < 75) ? OP_POP :
                              (roll < 80) ? OP_PEEK : (roll < 88) ? OP_DISPLAY :
                              (roll < 96) ? OP_REVERSE : 3'd0;
                1:       op = (roll < 10) ? OP_PUSH : (roll < 70) ? OP_POP :
                              (roll < 80) ? OP_PEEK : (roll < 88) ? OP_DISPLAY :
                              (roll < 96) ? OP_REVERSE : 3'd0;
                default: op = (roll < 35) ? OP_PUSH : (roll < 60) ? OP_POP :
                              (roll < 72) ? OP_PEEK : (roll < 84) ? OP_DISPLAY :
                              (roll < 96) ? OP_REVERSE : 3'd0;
            endcase
            if (roll >= 96) op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            send_cmd(op, random_word());
            if (op <= OP_REVERSE) done++;
            seg--;
        end
        wait_all_replies();
    endtask

    initial begin : rx_stall_gen
        int rx_hold_left;
        int rx_run_left;
        rx_hold_left = 0;
        rx_run_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_stall <= 1'b1;
            end else if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = RX_HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (rx_run_left > 0) begin
                rx_run_left--;
            end else begin
                case (rx_mode)
                    0: begin
                        rx_run_left = $urandom_range(0, 20);
                        i_stall <= 1'b0;
                    end
                    1: begin
                        rx_run_left = $urandom_range(0, 3);
                        i_stall <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        rx_run_left = $urandom_range(0, 7);
                        i_stall <= $urandom_range(0, 1);
                    end
                endcase
            end
        end
    end

    initial begin : reply_checker
        t_stack_reply exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply status %0d data %0d",
                                              o_status, o_data));
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (o_status !== exp_r.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                                                  o_status, exp_r.status));
                    if (o_data !== exp_r.data)
                        report_mismatch($sformatf("data got %0d exp %0d",
                                                  o_data, exp_r.data));
                    if (o_last !== exp_r.last)
                        report_mismatch($sformatf("last got %0b exp %0b",
                                                  o_last, exp_r.last));
                    replies_checked++;
                end
            end
        end
    end

    initial begin : main_seq
        model_count = 0;
        foreach (op_count[i]) op_count[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_word_extremes();
        test_fill_to_overflow();
        test_backpressure_hold();
        test_random_mix(RANDOM_ITEMS);

        mismatch_count += expected_replies.size();
        $display("covered %0d push, %0d pop, %0d peek, %0d display, %0d reverse, %0d reserved",
                 op_count[OP_PUSH], op_count[OP_POP], op_count[OP_PEEK],
                 op_count[OP_DISPLAY], op_count[OP_REVERSE],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("%0d replies checked, %0d full and %0d empty statuses, %0d mismatches",
                 replies_checked, full_hits, empty_hits, mismatch_count);
        if (mismatch_count == 0) begin
            $display("lifo_stack_with_reverse_unit test passed");
        end else begin
            $display("lifo_stack_with_reverse_unit test failed");
        end
        $finish;
    end

endmodule
